// ----- hdl/lrfp_pkg.sv -----
// Shared types and constants of the range-sensor frame parser.
`default_nettype none

package lrfp_pkg;

    // Request item: a bus frame or an alive-period tick
    typedef struct packed {
        logic        req_type;
        logic [2:0]  module_id;
        logic [7:0]  channel_id;
        logic [28:0] msg_id;
        logic [3:0]  data_len;
        logic [63:0] payload;
    } req_t;

    // Result item: a measurement or an alive status
    typedef struct packed {
        logic        result_kind;
        logic [15:0] range_cm;
        logic [15:0] signal_strength;
        logic [15:0] temperature_raw;
        logic [1:0]  range_class;
        logic [15:0] frame_rate;
        logic        is_online;
        logic        online_changed;
    } rsp_t;

    // Request kinds
    localparam logic REQ_FRAME = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    // Result kinds
    localparam logic KIND_MEAS  = 1'b0;
    localparam logic KIND_ALIVE = 1'b1;

    // Range classes
    localparam logic [1:0] CLASS_NORMAL = 2'd0;
    localparam logic [1:0] CLASS_ZERO   = 2'd1;
    localparam logic [1:0] CLASS_FAR    = 2'd2;
    localparam logic [1:0] CLASS_WEAK   = 2'd3;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MODULE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ID       = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_STRENGTH = 2'd3;
    localparam int CFG_DATA_W = 29;

    // Frame format and limits
    localparam logic [7:0]  HDR_BYTE         = 8'h59;
    localparam logic [15:0] DIST_FAR         = 16'd65532;
    localparam logic [15:0] STRENGTH_SAT     = 16'hFFFF;
    localparam logic [15:0] RATE_MAX         = 16'hFFFF;
    localparam logic [15:0] STRENGTH_MIN_RST = 16'd100;
    localparam logic [3:0]  LAST_POS         = 4'd8;

endpackage : lrfp_pkg

`default_nettype wire

// ----- hdl/lrfp_byte_ser.sv -----
// Payload serializer: shifts the accepted payload out one byte per cycle while step is high.
`default_nettype none

module lrfp_byte_ser #(
    parameter int MAX_PAYLOAD_BYTES = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  wire logic [3:0]  data_len,
    input  wire logic [63:0] payload,
    input  wire logic        step,
    output logic             busy,
    output logic [7:0]       byte_out
);

    localparam int SH_W  = 8 * MAX_PAYLOAD_BYTES;
    localparam int CNT_W = $clog2(MAX_PAYLOAD_BYTES + 1);

    logic [SH_W-1:0]  shift_reg;
    logic [SH_W-1:0]  shift_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] load_cnt;

    // Clip the length code to the payload limit
    always_comb
    begin
        if (data_len > 4'(MAX_PAYLOAD_BYTES))
            load_cnt = CNT_W'(MAX_PAYLOAD_BYTES);
        else
            load_cnt = CNT_W'(data_len);
    end

    // Load on accept, advance one byte per step
    always_comb
    begin
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        if (load)
        begin
            shift_next = payload[SH_W-1:0];
            cnt_next   = load_cnt;
        end
        else if (step && busy)
        begin
            shift_next = shift_reg >> 8;
            cnt_next   = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

    assign busy     = (cnt_reg != '0);
    assign byte_out = shift_reg[7:0];

endmodule : lrfp_byte_ser

`default_nettype wire

// ----- hdl/lrfp_parser.sv -----
// Nine-byte frame parser: header hunt, running checksum, field extraction.
`default_nettype none

module lrfp_parser (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         byte_valid,
    input  wire logic [7:0]   byte_in,
    input  wire logic [15:0]  strength_min,
    input  wire logic         can_emit,
    output logic              byte_take,
    output logic              meas_valid,
    output lrfp_pkg::rsp_t    meas
);

    logic [3:0]  pos_reg;
    logic [3:0]  pos_next;
    logic [7:0]  sum_reg;
    logic [7:0]  sum_next;
    logic [47:0] data_reg;
    logic [47:0] data_next;
    logic [15:0] meas_dist;
    logic [15:0] str;
    logic [15:0] temp;
    logic [1:0]  cls;
    logic        at_check;

    assign at_check   = (pos_reg == lrfp_pkg::LAST_POS);
    // Hold the checksum byte until the output side has room
    assign byte_take  = byte_valid && (!at_check || can_emit);
    assign meas_valid = byte_take && at_check && (sum_reg == byte_in);

    // Advance the header hunt and accumulate the frame
    always_comb
    begin
        pos_next  = pos_reg;
        sum_next  = sum_reg;
        data_next = data_reg;
        if (byte_take)
        begin
            case (pos_reg)
                4'd0:
                begin
                    if (byte_in == lrfp_pkg::HDR_BYTE)
                    begin
                        pos_next = 4'd1;
                        sum_next = byte_in;
                    end
                end
                4'd1:
                begin
                    if (byte_in == lrfp_pkg::HDR_BYTE)
                    begin
                        pos_next = 4'd2;
                        sum_next = sum_reg + byte_in;
                    end
                    else
                        pos_next = 4'd0;
                end
                lrfp_pkg::LAST_POS:
                begin
                    pos_next = 4'd0;
                end
                default:
                begin
                    pos_next  = pos_reg + 4'd1;
                    sum_next  = sum_reg + byte_in;
                    data_next = {byte_in, data_reg[47:8]};
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end

    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        data_reg <= data_next;
    end

    // Extract fields from data bytes two through seven
    assign meas_dist = data_reg[15:0];
    assign str       = data_reg[31:16];
    assign temp      = data_reg[47:32];

    // Classify the reading
    always_comb
    begin
        if (meas_dist == 16'd0)
            cls = lrfp_pkg::CLASS_ZERO;
        else if (meas_dist == lrfp_pkg::DIST_FAR)
            cls = lrfp_pkg::CLASS_FAR;
        else if (str < strength_min || str == lrfp_pkg::STRENGTH_SAT)
            cls = lrfp_pkg::CLASS_WEAK;
        else
            cls = lrfp_pkg::CLASS_NORMAL;
    end

    always_comb
    begin
        meas                 = '0;
        meas.result_kind     = lrfp_pkg::KIND_MEAS;
        meas.range_cm        = meas_dist;
        meas.signal_strength = str;
        meas.temperature_raw = temp;
        meas.range_class     = cls;
    end

endmodule : lrfp_parser

`default_nettype wire

// ----- hdl/lrfp_alive.sv -----
// Alive monitor: saturating frame counter and online flag per tick period.
`default_nettype none

module lrfp_alive #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       frame_hit,
    input  wire logic       tick_take,
    output lrfp_pkg::rsp_t  status
);

    localparam int WIDE_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic                   online_reg;
    logic                   online_next;
    logic [WIDE_W-1:0]      count_wide;
    logic                   now_on;
    logic [15:0]            rate;

    assign now_on     = (count_reg != '0);
    assign count_wide = WIDE_W'(count_reg);
    assign rate       = (count_wide > WIDE_W'(lrfp_pkg::RATE_MAX)) ?
                        lrfp_pkg::RATE_MAX : count_wide[15:0];

    // Clear on tick, count matching frames up to the limit
    always_comb
    begin
        count_next  = count_reg;
        online_next = online_reg;
        if (tick_take)
        begin
            count_next  = '0;
            online_next = now_on;
        end
        else if (frame_hit && !(&count_reg))
            count_next = count_reg + COUNT_WIDTH'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            online_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            online_reg <= online_next;
        end
    end

    always_comb
    begin
        status                = '0;
        status.result_kind    = lrfp_pkg::KIND_ALIVE;
        status.frame_rate     = rate;
        status.is_online      = now_on;
        status.online_changed = (now_on != online_reg);
    end

endmodule : lrfp_alive

`default_nettype wire

// ----- hdl/lidar_range_frame_parser.sv -----
// Range-sensor frame parser top level: frame filter, serializer, parser, output register.
// A matching frame loads the serializer, which feeds min(data_len, MAX_PAYLOAD_BYTES) payload
// bytes one per cycle while the parser takes them; requests stall while it is busy or a tick
// is pending. A measurement shows on rsp in the cycle after its checksum byte is parsed, an alive
// status after passing tick_pending_reg and rsp_reg. A checksum byte waits only while rsp stalls.
// Reset clears the header hunt, frame counter, online flag and loads register defaults.
`default_nettype none

module lidar_range_frame_parser #(
    parameter int MAX_PAYLOAD_BYTES = 8,
    parameter int COUNT_WIDTH       = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               req_valid,
    output logic                                    req_stall,
    input  wire lrfp_pkg::req_t                     req,
    output logic                                    rsp_valid,
    input  wire logic                               rsp_stall,
    output lrfp_pkg::rsp_t                          rsp,
    input  wire logic                               cfg_we,
    input  wire logic [lrfp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [lrfp_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [2:0]     module_match_reg;
    logic [7:0]     channel_match_reg;
    logic [28:0]    id_match_reg;
    logic [15:0]    strength_min_reg;

    logic           tick_pending_reg;
    logic           rsp_valid_reg;
    lrfp_pkg::rsp_t rsp_reg;

    logic           req_take;
    logic           frame_hit;
    logic           tick_take;
    logic           out_free;
    logic           ser_busy;
    logic [7:0]     ser_byte;
    logic           byte_take;
    logic           meas_valid;
    lrfp_pkg::rsp_t meas;
    lrfp_pkg::rsp_t status;

    // Input handshake and frame filter
    assign req_stall = ser_busy || tick_pending_reg;
    assign req_take  = req_valid && !req_stall;
    assign frame_hit = req_take && (req.req_type == lrfp_pkg::REQ_FRAME) &&
                       (req.module_id == module_match_reg) &&
                       (req.channel_id == channel_match_reg) &&
                       (req.msg_id == id_match_reg);

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign tick_take = tick_pending_reg && out_free;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            module_match_reg  <= '0;
            channel_match_reg <= '0;
            id_match_reg      <= '0;
            strength_min_reg  <= lrfp_pkg::STRENGTH_MIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lrfp_pkg::CFG_MODULE:   module_match_reg  <= cfg_data[2:0];
                lrfp_pkg::CFG_CHANNEL:  channel_match_reg <= cfg_data[7:0];
                lrfp_pkg::CFG_ID:       id_match_reg      <= cfg_data[28:0];
                lrfp_pkg::CFG_STRENGTH: strength_min_reg  <= cfg_data[15:0];
                default:                ;
            endcase
        end
    end

    lrfp_byte_ser #(
        .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
    ) u_ser (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (frame_hit),
        .data_len (req.data_len),
        .payload  (req.payload),
        .step     (byte_take),
        .busy     (ser_busy),
        .byte_out (ser_byte)
    );

    lrfp_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (ser_busy),
        .byte_in      (ser_byte),
        .strength_min (strength_min_reg),
        .can_emit     (out_free),
        .byte_take    (byte_take),
        .meas_valid   (meas_valid),
        .meas         (meas)
    );

    lrfp_alive #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_alive (
        .clk       (clk),
        .rst_n     (rst_n),
        .frame_hit (frame_hit),
        .tick_take (tick_take),
        .status    (status)
    );

    // Hold a tick until the output side has room; drop the valid on delivery
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_pending_reg <= 1'b0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            if (req_take && req.req_type == lrfp_pkg::REQ_TICK)
                tick_pending_reg <= 1'b1;
            else if (tick_take)
                tick_pending_reg <= 1'b0;

            if (meas_valid || tick_take)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Load the output register
    always_ff @(posedge clk)
    begin
        if (meas_valid)
            rsp_reg <= meas;
        else if (tick_take)
            rsp_reg <= status;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule : lidar_range_frame_parser

`default_nettype wire

// ----- tb/lrfp_checker.sv -----
`timescale 1ns / 1ps
// Result checker for the range-sensor frame parser: tracks register writes, predicts, compares.
module lrfp_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 req_valid,
    input  logic                                 req_stall,
    input  lrfp_pkg::req_t                       req,
    input  logic                                 rsp_valid,
    input  logic                                 rsp_stall,
    input  lrfp_pkg::rsp_t                       rsp,
    input  logic                                 cfg_we,
    input  logic [lrfp_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [lrfp_pkg::CFG_DATA_W-1:0]      cfg_data,
    output int                                   mismatches,
    output int                                   owed
);
    import lrfp_pkg::*;

    localparam int PAYLOAD_LIMIT = 8;
    localparam int REPORT_LIMIT  = 10;

    // Mirrored register file
    logic [2:0]  want_module;
    logic [7:0]  want_channel;
    logic [28:0] want_id;
    logic [15:0] min_strength;

    // Parser and alive-period state
    logic [3:0]  hunt_pos;
    logic [7:0]  held_bytes [8];
    logic [15:0] frames_seen;
    logic        online_now;

    // Results still to come, oldest first
    rsp_t owed_q [$];

    function automatic string show(input rsp_t r);
        return $sformatf({"kind=%0d dist=%0d str=%0d temp=%0d class=%0d",
                          " rate=%0d online=%0d chg=%0d"},
                         r.result_kind, r.range_cm, r.signal_strength, r.temperature_raw,
                         r.range_class, r.frame_rate, r.is_online, r.online_changed);
    endfunction

    // Push one payload byte through the nine-byte frame parser
    task automatic take_byte(input logic [7:0] b);
        logic [7:0] sum;
        rsp_t       m;
        if (hunt_pos < 4'd2 && b != HDR_BYTE)
        begin
            // drop the byte and hunt for the first header again
            hunt_pos = 4'd0;
        end
        else if (hunt_pos < LAST_POS)
        begin
            held_bytes[hunt_pos[2:0]] = b;
            hunt_pos++;
        end
        else
        begin
            hunt_pos = 4'd0;
            sum = 8'h00;
            foreach (held_bytes[i])
                sum += held_bytes[i];
            if (sum == b)
            begin
                m = '0;
                m.result_kind     = KIND_MEAS;
                m.range_cm        = {held_bytes[3], held_bytes[2]};
                m.signal_strength = {held_bytes[5], held_bytes[4]};
                m.temperature_raw = {held_bytes[7], held_bytes[6]};
                if (m.range_cm == 16'd0)
                    m.range_class = CLASS_ZERO;
                else if (m.range_cm == DIST_FAR)
                    m.range_class = CLASS_FAR;
                else if (m.signal_strength < min_strength || m.signal_strength == STRENGTH_SAT)
                    m.range_class = CLASS_WEAK;
                else
                    m.range_class = CLASS_NORMAL;
                owed_q.push_back(m);
            end
        end
    endtask

    // Work out what one accepted request leads to
    task automatic predict(input req_t r);
        rsp_t a;
        int   n;
        if (r.req_type == REQ_TICK)
        begin
            a = '0;
            a.result_kind    = KIND_ALIVE;
            a.frame_rate     = frames_seen;
            a.is_online      = (frames_seen != 16'd0);
            a.online_changed = (a.is_online != online_now);
            online_now  = a.is_online;
            frames_seen = 16'd0;
            owed_q.push_back(a);
        end
        else if (r.module_id == want_module && r.channel_id == want_channel &&
                 r.msg_id == want_id)
        begin
            // counter width equals the rate width, so both saturate together
            if (frames_seen != RATE_MAX)
                frames_seen++;
            n = (int'(r.data_len) > PAYLOAD_LIMIT) ? PAYLOAD_LIMIT : int'(r.data_len);
            for (int i = 0; i < n; i++)
                take_byte(r.payload[8*i +: 8]);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        rsp_t want;
        if (!rst_n)
        begin
            want_module  = 3'd0;
            want_channel = 8'd0;
            want_id      = 29'd0;
            min_strength = STRENGTH_MIN_RST;
            hunt_pos     = 4'd0;
            frames_seen  = 16'd0;
            online_now   = 1'b0;
            owed_q.delete();
        end
        else
        begin
            // compare the result transaction with the oldest prediction
            if (rsp_valid && !rsp_stall)
            begin
                if (owed_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: result with none expected: %s", $time, show(rsp));
                end
                else
                begin
                    want = owed_q.pop_front();
                    if (rsp !== want)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                        begin
                            $display("%0t: result mismatch", $time);
                            $display("    expected %s", show(want));
                            $display("    actual   %s", show(rsp));
                        end
                    end
                end
            end

            // track register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MODULE:   want_module  = cfg_data[2:0];
                    CFG_CHANNEL:  want_channel = cfg_data[7:0];
                    CFG_ID:       want_id      = cfg_data[28:0];
                    CFG_STRENGTH: min_strength = cfg_data[15:0];
                    default:      ;
                endcase
            end

            if (req_valid && !req_stall)
                predict(req);
        end
        owed = owed_q.size();
    end

endmodule

// ----- tb/tb_lidar_range_frame_parser.sv -----
`timescale 1ns / 1ps
// Testbench top for the range-sensor frame parser: clock, reset, register setup, traffic, verdict.
module tb_lidar_range_frame_parser;
    import lrfp_pkg::*;

    localparam int SETTLE_CYCLES  = 24;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PATTERN} rx_mode_e;

    logic                   clk;
    logic                   rst_n;
    logic                   req_valid;
    logic                   req_stall;
    req_t                   req;
    logic                   rsp_valid;
    logic                   rsp_stall = 1'b0;
    rsp_t                   rsp;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int checker_errors;
    int results_owed;

    // Register values in force, used to build frames that pass the filter
    logic [2:0]  sel_module;
    logic [7:0]  sel_channel;
    logic [28:0] sel_id;
    logic [15:0] sel_strength;

    logic [7:0] tx_bytes [$];
    int         burst_left;
    int         items_sent;
    int         idle_cycles;
    rx_mode_e   rx_mode;
    int         rx_span;

    lidar_range_frame_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lrfp_checker result_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (checker_errors),
        .owed       (results_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Stall the result side on a changing pattern
    always @(negedge clk)
    begin
        if (rx_span == 0)
        begin
            rx_mode = rx_mode_e'($urandom_range(0, 3));
            rx_span = $urandom_range(8, 64);
        end
        rx_span--;
        case (rx_mode)
            RX_OPEN:  rsp_stall <= 1'b0;
            RX_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            RX_HEAVY: rsp_stall <= ($urandom_range(0, 1) == 1);
            default:  rsp_stall <= ((rx_span % 8) < 5);
        endcase
    end

    // Abort when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_we)
            idle_cycles <= 0;
        else if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Offer one request transaction and hold it until it is taken
    task automatic send_req(input req_t item);
        @(negedge clk);
        if (burst_left == 0)
        begin
            req_valid <= 1'b0;
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6))
                @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
        req_valid <= 1'b1;
        req       <= item;
        if (burst_left > 0)
            burst_left--;
        items_sent++;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    // Stop sending, wait for every result, then let the parser run dry
    task automatic settle();
        @(negedge clk);
        req_valid <= 1'b0;
        burst_left = 0;
        while (results_owed != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
    endtask

    // Load all four registers; unused upper bits carry junk
    task automatic write_regs(input logic [2:0] m, input logic [7:0] c, input logic [28:0] id,
                              input logic [15:0] s);
        logic [31:0] junk;
        junk = $urandom;
        put_reg(CFG_MODULE, {junk[CFG_DATA_W-1:3], m});
        put_reg(CFG_CHANNEL, {junk[CFG_DATA_W-1:8], c});
        put_reg(CFG_ID, id);
        put_reg(CFG_STRENGTH, {junk[CFG_DATA_W-1:16], s});
        @(negedge clk);
        cfg_we <= 1'b0;
        sel_module   = m;
        sel_channel  = c;
        sel_id       = id;
        sel_strength = s;
    endtask

    function automatic req_t bus_frame(input logic [63:0] pl, input logic [3:0] code);
        req_t f;
        f.req_type   = REQ_FRAME;
        f.module_id  = sel_module;
        f.channel_id = sel_channel;
        f.msg_id     = sel_id;
        f.data_len   = code;
        f.payload    = pl;
        return f;
    endfunction

    // Frame that misses the filter, mostly by one field
    function automatic req_t foreign_frame();
        req_t f;
        f = bus_frame({$urandom, $urandom}, 4'($urandom_range(0, 15)));
        case ($urandom_range(0, 4))
            0: f.module_id  ^= 3'($urandom_range(1, 7));
            1: f.channel_id ^= 8'($urandom_range(1, 255));
            2: f.msg_id     ^= 29'(1) << $urandom_range(0, 28);
            3: f.msg_id     ^= 29'($urandom_range(1, 29'h1FFFFFFF));
            default:
            begin
                f.module_id  = 3'($urandom);
                f.channel_id = 8'($urandom);
                f.msg_id     = 29'($urandom);
            end
        endcase
        return f;
    endfunction

    // Tick with junk in every field it ignores
    function automatic req_t tick_item();
        logic [127:0] raw;
        req_t         t;
        raw = {$urandom, $urandom, $urandom, $urandom};
        t = raw[$bits(req_t)-1:0];
        t.req_type = REQ_TICK;
        return t;
    endfunction

    // Pop up to eight queued bytes into a payload, junk above them
    function automatic logic [63:0] take_bytes(input int n);
        logic [63:0] pl;
        pl = {$urandom, $urandom};
        for (int i = 0; i < n; i++)
            pl[8*i +: 8] = tx_bytes.pop_front();
        return pl;
    endfunction

    task automatic push_packet(input logic [15:0] dist_cm, input logic [15:0] strength,
                               input logic [15:0] temp, input bit corrupt);
        logic [7:0] pkt [8];
        logic [7:0] sum;
        pkt = '{HDR_BYTE, HDR_BYTE, dist_cm[7:0], dist_cm[15:8], strength[7:0], strength[15:8],
                temp[7:0], temp[15:8]};
        sum = 8'h00;
        foreach (pkt[i])
        begin
            sum += pkt[i];
            tx_bytes.push_back(pkt[i]);
        end
        if (corrupt)
            sum ^= 8'($urandom_range(1, 255));
        tx_bytes.push_back(sum);
    endtask

    // Ship the queued byte stream in frames of random length, optionally interleaved
    task automatic flush_bytes(input bit mixed);
        int         n;
        logic [3:0] code;
        while (tx_bytes.size() != 0)
        begin
            n = $urandom_range(1, 8);
            if (n > tx_bytes.size())
                n = tx_bytes.size();
            code = 4'(n);
            if (n == 8 && $urandom_range(0, 1) == 1)
                code = 4'($urandom_range(9, 15));
            send_req(bus_frame(take_bytes(n), code));
            if (mixed)
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2: send_req(foreign_frame());
                    3:       send_req(tick_item());
                    4:       send_req(bus_frame({$urandom, $urandom}, 4'd0));
                    default: ;
                endcase
            end
        end
    endtask

    function automatic logic [15:0] pick_distance();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return DIST_FAR;
            2:       return 16'hFFFF;
            3:       return DIST_FAR - 16'd1;
            4:       return DIST_FAR + 16'd1;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_strength();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return STRENGTH_SAT;
            2:       return sel_strength - 16'd1;
            3:       return sel_strength;
            4:       return sel_strength + 16'd1;
            default: return 16'($urandom);
        endcase
    endfunction

    // Queue one sensor packet, sometimes behind a stray byte or a false header
    task automatic queue_reading();
        case ($urandom_range(0, 9))
            0: tx_bytes.push_back(8'($urandom));
            1:
            begin
                tx_bytes.push_back(HDR_BYTE);
                tx_bytes.push_back(8'($urandom));
            end
            default: ;
        endcase
        push_packet(pick_distance(), pick_strength(), 16'($urandom), $urandom_range(0, 9) == 0);
    endtask

    task automatic random_traffic(input int quota);
        int start;
        start = items_sent;
        while (items_sent - start < quota)
        begin
            case ($urandom_range(0, 15))
                0: send_req(tick_item());
                1:
                begin
                    send_req(tick_item());
                    send_req(tick_item());
                end
                2: send_req(foreign_frame());
                3: send_req(bus_frame({$urandom, $urandom}, 4'($urandom_range(0, 15))));
                default:
                begin
                    repeat ($urandom_range(1, 3))
                        queue_reading();
                    flush_bytes(1'b1);
                end
            endcase
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_MODULE;
        cfg_data     = '0;
        sel_module   = 3'd0;
        sel_channel  = 8'd0;
        sel_id       = 29'd0;
        sel_strength = STRENGTH_MIN_RST;
        burst_left   = 0;
        items_sent   = 0;
        rx_span      = 0;
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed checks on the reset register values
        send_req(tick_item());
        push_packet(16'd0, 16'd500, 16'd2248, 1'b0);
        send_req(bus_frame(take_bytes(8), 4'd15));
        push_packet(DIST_FAR, 16'd500, 16'd2300, 1'b0);
        push_packet(16'd1200, STRENGTH_SAT, 16'd2048, 1'b0);
        push_packet(16'd1200, STRENGTH_MIN_RST - 16'd1, 16'hFFFF, 1'b0);
        push_packet(16'hFFFF, STRENGTH_MIN_RST, 16'd0, 1'b0);
        push_packet(16'd300, 16'd800, 16'd2100, 1'b1);
        // stray byte, then a header byte followed by a non-header byte
        tx_bytes.push_back(8'h12);
        tx_bytes.push_back(HDR_BYTE);
        tx_bytes.push_back(8'h33);
        push_packet(16'd450, 16'd900, 16'd2200, 1'b0);
        flush_bytes(1'b0);
        send_req(bus_frame({$urandom, $urandom}, 4'd0));
        send_req(foreign_frame());
        send_req(foreign_frame());
        send_req(tick_item());
        send_req(tick_item());
        settle();

        // Random traffic under several register settings
        write_regs(3'd7, 8'hFF, 29'h1FFFFFFF, 16'hFFFF);
        random_traffic(250);
        settle();
        write_regs(3'd0, 8'h00, 29'h0, 16'h0);
        random_traffic(250);
        settle();
        repeat (3)
        begin
            write_regs(3'($urandom), 8'($urandom), 29'($urandom),
                       16'($urandom_range(0, 3000)));
            random_traffic(300);
            settle();
        end

        if (checker_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/lrfp_pkg.sv
hdl/lrfp_byte_ser.sv
hdl/lrfp_parser.sv
hdl/lrfp_alive.sv
hdl/lidar_range_frame_parser.sv
tb/lrfp_checker.sv
tb/tb_lidar_range_frame_parser.sv
